@@ hdl/piecewise_linear_boundary_check_assert.svh @@
// Assertion macros used by the checker file.
`ifndef PIECEWISE_LINEAR_BOUNDARY_CHECK_ASSERT_SVH
`define PIECEWISE_LINEAR_BOUNDARY_CHECK_ASSERT_SVH

// Checked only outside reset.
`define PWLBC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PWLBC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/pwlbc_pkg.sv @@
// Types, constants and codes of the piecewise linear boundary check.
`timescale 1ns / 1ps

package pwlbc_pkg;

    localparam int MAX_POINTS  = 32;
    localparam int COORD_BITS  = 12;
    localparam int MARGIN_BITS = 12;
    localparam int CNT_BITS    = $clog2(MAX_POINTS + 1);
    localparam int IDX_BITS    = $clog2(MAX_POINTS);
    localparam int STEP_BITS   = $clog2(COORD_BITS);
    localparam int SUM_BITS    =
        ((COORD_BITS > MARGIN_BITS) ? COORD_BITS : MARGIN_BITS) + 1;

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_FEW  = 2'd2;

    typedef struct packed {
        logic [1:0]            req_type;
        logic [COORD_BITS-1:0] coord_x;
        logic [COORD_BITS-1:0] coord_y;
    } t_item;

    typedef struct packed {
        logic [COORD_BITS-1:0] boundary_y;
        logic                  in_field;
        logic [1:0]            status;
    } t_result;

    // Search token handed from cell to cell
    typedef struct packed {
        logic                  act;
        logic                  done;
        logic                  direct;
        logic [COORD_BITS-1:0] qx;
        logic [COORD_BITS-1:0] x1;
        logic [COORD_BITS-1:0] y1;
        logic [COORD_BITS-1:0] x2;
        logic [COORD_BITS-1:0] y2;
    } t_token;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DIVIDE
    } t_state;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_MUL,
        DV_ITER,
        DV_FIN
    } t_div_state;

endpackage

@@ hdl/piecewise_linear_boundary_check.sv @@
// Top level: control, point count, margin register, the row of table cells and the divider.
`timescale 1ns / 1ps

// One item at a time. Busy stays high until the result strobe rises, and the
// result strobe o_valid is high for exactly one cycle. Clear, append,
// unused codes and queries against fewer than two points give their result
// in the cycle after acceptance. A query runs a token down the row of
// MAX_POINTS cells, one cell per cycle. When it lands on a stored x or
// outside the table, its result follows once the token leaves the last cell;
// when it interpolates, the divider first does a multiply, then a bit-serial
// divide and a finish step that hands the result back. The receiver cannot
// stall a result. The margin register is always ready and must be written
// only while busy is low.

module piecewise_linear_boundary_check import pwlbc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  t_item                  i_item,
    output logic                   o_valid,
    output t_result                o_res,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [MARGIN_BITS-1:0] i_cfg_data
);

    t_state                 r_state;
    t_state                 n_state;
    logic [CNT_BITS-1:0]    r_count;
    logic [CNT_BITS-1:0]    n_count;
    logic [MARGIN_BITS-1:0] r_margin;
    logic [COORD_BITS-1:0]  r_qy;
    logic                   r_valid;
    logic                   n_valid;
    t_result                r_res;
    t_result                n_res;
    logic                   accept;
    logic                   is_query;
    logic                   few;
    logic                   full;
    logic                   wr_en;
    logic                   div_start;
    logic                   div_done;
    logic [COORD_BITS-1:0]  div_y;
    logic                   need_div;
    t_token                 tok_head;
    t_token                 tok_chain [0:MAX_POINTS];
    t_token                 tok_end;

    function automatic logic above(input logic [COORD_BITS-1:0]  y,
                                   input logic [COORD_BITS-1:0]  by,
                                   input logic [MARGIN_BITS-1:0] m);
        logic [SUM_BITS-1:0] lhs;
        logic [SUM_BITS-1:0] rhs;
        // y > by - m, rearranged to stay unsigned
        lhs = SUM_BITS'(y) + SUM_BITS'(m);
        rhs = SUM_BITS'(by);
        return lhs > rhs;
    endfunction

    assign busy         = (r_state != S_IDLE);
    assign accept       = start && !busy;
    assign is_query     = (i_item.req_type == REQ_QUERY);
    assign few          = r_count < CNT_BITS'(2);
    assign full         = r_count >= CNT_BITS'(MAX_POINTS);
    assign o_cfg_ready  = 1'b1;
    assign tok_chain[0] = tok_head;
    assign tok_end      = tok_chain[MAX_POINTS];
    assign need_div     = tok_end.done && !tok_end.direct;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (accept && is_query && !few) n_state = S_SEARCH;
            S_SEARCH: if (tok_end.act) n_state = need_div ? S_DIVIDE : S_IDLE;
            S_DIVIDE: if (div_done) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        n_valid   = 1'b0;
        n_res     = '0;
        n_count   = r_count;
        wr_en     = 1'b0;
        div_start = 1'b0;
        tok_head  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_item.req_type)
                        REQ_CLEAR: begin
                            n_valid = 1'b1;
                            n_count = '0;
                        end
                        REQ_APPEND: begin
                            n_valid = 1'b1;
                            if (full) begin
                                n_res.status = ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        REQ_QUERY: begin
                            if (few) begin
                                n_valid        = 1'b1;
                                n_res.status   = ST_FEW;
                                n_res.in_field = above(i_item.coord_y, '0, r_margin);
                            end else begin
                                tok_head.act = 1'b1;
                                tok_head.qx  = i_item.coord_x;
                            end
                        end
                        default: n_valid = 1'b1;
                    endcase
                end
            end
            S_SEARCH: begin
                if (tok_end.act) begin
                    if (need_div) begin
                        div_start = 1'b1;
                    end else begin
                        // exact hit, below the first or past the last point
                        n_valid          = 1'b1;
                        n_res.boundary_y = tok_end.y1;
                        n_res.in_field   = above(r_qy, tok_end.y1, r_margin);
                    end
                end
            end
            S_DIVIDE: begin
                if (div_done) begin
                    n_valid          = 1'b1;
                    n_res.boundary_y = div_y;
                    n_res.in_field   = above(r_qy, div_y, r_margin);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_margin <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_margin <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (accept) begin
            r_qy <= i_item.coord_y;
        end
    end

    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
        pwlbc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (IDX_BITS'(g)),
            .i_count    (r_count),
            .i_wr       (wr_en),
            .i_wx       (i_item.coord_x),
            .i_wy       (i_item.coord_y),
            .i_tok      (tok_chain[g]),
            .o_tok      (tok_chain[g+1])
        );
    end

    pwlbc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_tok   (tok_end),
        .o_done  (div_done),
        .o_y     (div_y)
    );

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

@@ hdl/pwlbc_cell.sv @@
// One table cell: holds a boundary point and passes the search token on.
`timescale 1ns / 1ps

module pwlbc_cell import pwlbc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [IDX_BITS-1:0]   i_cell_idx,
    input  logic [CNT_BITS-1:0]   i_count,
    input  logic                  i_wr,
    input  logic [COORD_BITS-1:0] i_wx,
    input  logic [COORD_BITS-1:0] i_wy,
    input  t_token                i_tok,
    output t_token                o_tok
);

    logic [COORD_BITS-1:0] r_x;
    logic [COORD_BITS-1:0] r_y;
    t_token                r_tok;
    t_token                n_tok;
    logic                  occupied;

    assign occupied = CNT_BITS'(i_cell_idx) < i_count;

    always_ff @(posedge i_clk) begin
        if (i_wr && (CNT_BITS'(i_cell_idx) == i_count)) begin
            r_x <= i_wx;
            r_y <= i_wy;
        end
    end

    always_comb begin
        n_tok = i_tok;
        if (i_tok.act && !i_tok.done && occupied) begin
            if (r_x >= i_tok.qx) begin
                n_tok.done = 1'b1;
                if ((r_x == i_tok.qx) || (i_cell_idx == '0)) begin
                    // exact hit or below the first point: take this y
                    n_tok.direct = 1'b1;
                    n_tok.y1     = r_y;
                end else begin
                    n_tok.x2 = r_x;
                    n_tok.y2 = r_y;
                end
            end else begin
                n_tok.x1 = r_x;
                n_tok.y1 = r_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

@@ hdl/pwlbc_div.sv @@
// Interpolation unit: one multiply, then a bit-serial restoring divide.
`timescale 1ns / 1ps

module pwlbc_div import pwlbc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  t_token                i_tok,
    output logic                  o_done,
    output logic [COORD_BITS-1:0] o_y
);

    localparam int W2 = 2 * COORD_BITS;

    t_div_state            r_state;
    t_div_state            n_state;
    logic [COORD_BITS-1:0] r_dx;
    logic [COORD_BITS-1:0] r_t;
    logic [COORD_BITS-1:0] r_ady;
    logic                  r_neg;
    logic [COORD_BITS-1:0] r_y1;
    logic [COORD_BITS-1:0] r_rem;
    logic [COORD_BITS-1:0] r_quo;
    logic [STEP_BITS-1:0]  r_step;
    logic [W2-1:0]         prod;
    logic [COORD_BITS:0]   trial;
    logic [COORD_BITS:0]   diff;
    logic                  ge;
    logic                  neg;

    assign neg   = i_tok.y2 < i_tok.y1;
    assign prod  = W2'(r_ady) * W2'(r_t);
    assign trial = {r_rem, r_quo[COORD_BITS-1]};
    assign diff  = trial - {1'b0, r_dx};
    assign ge    = trial >= {1'b0, r_dx};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            DV_IDLE: if (i_start) n_state = DV_MUL;
            DV_MUL:  n_state = DV_ITER;
            DV_ITER: if (r_step == STEP_BITS'(COORD_BITS - 1)) n_state = DV_FIN;
            DV_FIN:  n_state = DV_IDLE;
            default: n_state = DV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            DV_IDLE: begin
                if (i_start) begin
                    r_dx  <= i_tok.x2 - i_tok.x1;
                    r_t   <= i_tok.qx - i_tok.x1;
                    r_neg <= neg;
                    r_ady <= neg ? (i_tok.y1 - i_tok.y2) : (i_tok.y2 - i_tok.y1);
                    r_y1  <= i_tok.y1;
                end
            end
            DV_MUL: begin
                // t < dx, so the upper half is already below the divisor
                r_rem  <= prod[W2-1:COORD_BITS];
                r_quo  <= prod[COORD_BITS-1:0];
                r_step <= '0;
            end
            DV_ITER: begin
                r_rem  <= ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
                r_quo  <= {r_quo[COORD_BITS-2:0], ge};
                r_step <= r_step + 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_done = (r_state == DV_FIN);
        o_y    = r_neg ? (r_y1 - r_quo) : (r_y1 + r_quo);
    end

endmodule

@@ hdl/pwlbc_checker.sv @@
// Port-level checks of the boundary check block, bound to the top level.
`timescale 1ns / 1ps
`include "piecewise_linear_boundary_check_assert.svh"

module pwlbc_checker import pwlbc_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input logic    o_valid,
    input t_result o_res
);

    `PWLBC_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> (!o_valid && !busy), "reset left the block active")
    `PWLBC_ASSERT(a_item_answered, i_clk, i_rst_n, (start && !busy) |=> (busy || o_valid), "accepted item neither worked on nor answered")
    `PWLBC_ASSERT(a_result_idle, i_clk, i_rst_n, o_valid |-> !busy, "result issued while still busy")
    `PWLBC_ASSERT(a_busy_cause, i_clk, i_rst_n, $rose(busy) |-> $past(start), "busy rose without an accepted item")
    `PWLBC_ASSERT(a_no_boundary, i_clk, i_rst_n, (o_valid && (o_res.status == ST_FULL || o_res.status == ST_FEW)) |-> (o_res.boundary_y == '0), "boundary given without a valid table")

endmodule

bind piecewise_linear_boundary_check pwlbc_checker u_pwlbc_checker (.*);
